FILE: design/hci_h4_rx_deframer_top_macros.svh
// Assertion helpers for the deframer; clocked on clk, held off while rst_n is low.
`ifndef HCI_H4_RX_DEFRAMER_TOP_MACROS_SVH
`define HCI_H4_RX_DEFRAMER_TOP_MACROS_SVH

// same-cycle implication
`define HH4_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer check failed");

// next-cycle implication
`define HH4_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer check failed");

`endif

FILE: design/hh4_pkg.sv
package hh4_pkg;

  localparam logic [7:0] PKT_ACL   = 8'h02;
  localparam logic [7:0] PKT_EVENT = 8'h04;

  localparam logic [15:0] MAX_ACL_RESET = 16'd251;

  // configuration register indexes
  localparam logic CFG_ENABLE  = 1'b0;
  localparam logic CFG_MAX_ACL = 1'b1;

  typedef enum logic [2:0] {
    PH_TYPE     = 3'd0,
    PH_EVT_CODE = 3'd1,
    PH_EVT_LEN  = 3'd2,
    PH_HDL_LO   = 3'd3,
    PH_HDL_HI   = 3'd4,
    PH_LEN_LO   = 3'd5,
    PH_LEN_HI   = 3'd6,
    PH_PAYLOAD  = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_BAD_TYPE = 2'd1,
    ERR_TOO_LONG = 2'd2,
    ERR_DISABLED = 2'd3
  } err_t;

  typedef struct packed {
    logic        packet_kind;
    logic [15:0] tag;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last;
    err_t        error_code;
  } result_t;

  // parser to output stage
  typedef struct packed {
    logic    valid;
    result_t res;
  } res_bus_t;

endpackage

FILE: design/hh4_in_stage.sv
module hh4_in_stage
  import hh4_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_byte;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

FILE: design/hh4_parser.sv
module hh4_parser
  import hh4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  byte_in,
  input  logic        enable,
  input  logic [15:0] max_acl_length,
  output res_bus_t    res_bus
);

  phase_t      phase_r, phase_nxt;
  logic        kind_r, kind_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] cnt_inc;
  logic [15:0] acl_len;
  logic        fin;
  res_bus_t    rb;

  assign cnt_inc = cnt_r + 16'd1;
  assign fin     = (cnt_inc >= len_r);
  assign acl_len = {byte_in, len_r[7:0]};

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    tag_nxt   = tag_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    rb        = '0;
    rb.res.error_code = ERR_NONE;

    if (!enable) begin
      phase_nxt = PH_TYPE;
      cnt_nxt   = '0;
      rb.valid  = 1'b1;
      rb.res.error_code = ERR_DISABLED;
    end else begin
      case (phase_r)
        PH_TYPE: begin
          if (byte_in == PKT_EVENT) begin
            kind_nxt  = 1'b0;
            phase_nxt = PH_EVT_CODE;
          end else if (byte_in == PKT_ACL) begin
            kind_nxt  = 1'b1;
            phase_nxt = PH_HDL_LO;
          end else begin
            rb.valid = 1'b1;
            rb.res.error_code = ERR_BAD_TYPE;
          end
        end
        PH_EVT_CODE: begin
          tag_nxt   = {8'd0, byte_in};
          phase_nxt = PH_EVT_LEN;
        end
        PH_EVT_LEN: begin
          len_nxt = {8'd0, byte_in};
          cnt_nxt = '0;
          if (byte_in == 8'd0) begin
            rb.valid              = 1'b1;
            rb.res.packet_kind    = kind_r;
            rb.res.tag            = tag_r;
            rb.res.last           = 1'b1;
            phase_nxt             = PH_TYPE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_HDL_LO: begin
          tag_nxt   = {8'd0, byte_in};
          phase_nxt = PH_HDL_HI;
        end
        PH_HDL_HI: begin
          tag_nxt   = {byte_in, tag_r[7:0]};
          phase_nxt = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_nxt   = {8'd0, byte_in};
          phase_nxt = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_nxt = acl_len;
          cnt_nxt = '0;
          if (acl_len > max_acl_length) begin
            rb.valid              = 1'b1;
            rb.res.packet_kind    = 1'b1;
            rb.res.tag            = tag_r;
            rb.res.payload_length = acl_len;
            rb.res.error_code     = ERR_TOO_LONG;
            phase_nxt             = PH_TYPE;
          end else if (acl_len == 16'd0) begin
            rb.valid           = 1'b1;
            rb.res.packet_kind = kind_r;
            rb.res.tag         = tag_r;
            rb.res.last        = 1'b1;
            phase_nxt          = PH_TYPE;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          rb.valid              = 1'b1;
          rb.res.packet_kind    = kind_r;
          rb.res.tag            = tag_r;
          rb.res.payload_length = len_r;
          rb.res.data_byte      = byte_in;
          rb.res.data_valid     = 1'b1;
          rb.res.last           = fin;
          if (fin) begin
            phase_nxt = PH_TYPE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TYPE;
      kind_r  <= 1'b0;
      tag_r   <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    res_bus       = rb;
    res_bus.valid = rb.valid && fire;
  end

endmodule

FILE: design/hh4_out_stage.sv
module hh4_out_stage
  import hh4_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  res_bus_t res_bus,
  input  logic     out_ready,
  output logic     out_valid,
  output logic     can_load,
  output result_t  out_res
);

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  // room for a new result once the held one is gone or leaving now
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (can_load) begin
      out_valid_nxt = res_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_bus.valid && can_load) begin
      out_res_r <= res_bus.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: design/hci_h4_rx_deframer_top.sv
// HCI H4 receive deframer.
// Input channel: one transport byte per transaction on in_byte (in_valid/in_ready).
// Output channel: at most one result per byte on out_* (out_valid/out_ready):
//   every payload byte with its packet kind, tag and declared length, the final
//   one flagged out_last; a zero-length packet gives one out_last result with no
//   data; header bytes give nothing. Errors (unknown type, ACL length above
//   max_acl_length, byte while disabled) give one result with out_error_code set
//   and send the parser back to hunting for a type byte.
// Config: cfg_we/cfg_index/cfg_wdata, index 0 enable, index 1 max_acl_length.
//   Write only while no transaction is in flight.
// Path: an accepted byte is held in the input register, then the parse logic
//   loads its result into the result register, which drives out_valid; a stall
//   at the output can keep the byte waiting in the input register in between.
// Throughput: one byte per cycle, limited by the single parse step and by out_ready.
// Reset (rst_n low, synchronous): both stages empty, parser hunting, enable 0,
//   max_acl_length 251.
// Stall: with out_ready low the result register holds, one more byte waits in
//   the input register, then in_ready drops until the result is taken.
module hci_h4_rx_deframer_top
  import hh4_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_packet_kind,
  output logic [15:0] out_tag,
  output logic [15:0] out_payload_length,
  output logic [7:0]  out_data_byte,
  output logic        out_data_valid,
  output logic        out_last,
  output logic [1:0]  out_error_code
);

`include "hci_h4_rx_deframer_top_macros.svh"

  logic        enable_r;
  logic [15:0] max_acl_r;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        can_load;
  logic        fire;
  res_bus_t    res_bus;
  result_t     out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r  <= 1'b0;
      max_acl_r <= MAX_ACL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:  enable_r  <= cfg_wdata[0];
        CFG_MAX_ACL: max_acl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign fire = s1_valid && can_load;

  hh4_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .advance  (can_load),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  hh4_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .byte_in        (s1_byte),
    .enable         (enable_r),
    .max_acl_length (max_acl_r),
    .res_bus        (res_bus)
  );

  hh4_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_bus   (res_bus),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (can_load),
    .out_res   (out_res)
  );

  assign out_packet_kind    = out_res.packet_kind;
  assign out_tag            = out_res.tag;
  assign out_payload_length = out_res.payload_length;
  assign out_data_byte      = out_res.data_byte;
  assign out_data_valid     = out_res.data_valid;
  assign out_last           = out_res.last;
  assign out_error_code     = out_res.error_code;

  `HH4_ASSERT_NOW(a_data_no_err, out_valid && out_data_valid, out_error_code == ERR_NONE)
  `HH4_ASSERT_NOW(a_err_not_last, out_valid && (out_error_code != ERR_NONE), !out_last)
  `HH4_ASSERT_NOW(a_full_blocks_in, s1_valid && out_valid && !out_ready, !in_ready)
  `HH4_ASSERT_NEXT(a_disabled_err, fire && !enable_r, out_valid && (out_error_code == ERR_DISABLED))

endmodule
